>>> hdl/scpa_pkg.sv
// Shared types, constants and a helper function of the size-class pool allocator.
package scpa_pkg;

	localparam int NUM_CLASSES = 16;
	localparam int CHUNKS      = 1024;
	localparam int CLS_W       = $clog2(NUM_CLASSES);
	localparam int IDX_W       = $clog2(CHUNKS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ADDR_W      = CLS_W + IDX_W;
	localparam int LINK_DEPTH  = NUM_CLASSES * CHUNKS;
	localparam int OFF_W       = 40;
	localparam int LG_MIN      = 3;
	localparam int LG_MAX      = 12;

	typedef enum logic [1:0] {
		ACT_ALLOC    = 2'd0,
		ACT_FREE     = 2'd1,
		ACT_FREE_ALL = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_ADDR  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_MIN_LOG2  = 2'd0,
		REG_MAX_FAST  = 2'd1,
		REG_ACTIVE    = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	// Effective configuration handed from the register block to the datapath.
	typedef struct packed {
		logic [3:0]       lg;
		logic [31:0]      max_fast;
		logic [CNT_W-1:0] act;
		logic [CLS_W:0]   ncls;
	} cfg_t;

	// Smallest r with 2^r >= v.
	function automatic logic [5:0] ceil_log2_32(input logic [31:0] v);
		logic [31:0] m;
		logic [5:0]  r;
		m = v - 32'd1;
		r = '0;
		if (v > 32'd1) begin
			for (int i = 0; i < 32; i++) begin
				if (m[i]) r = 6'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

>>> hdl/size_class_pool_allocator_top.sv
// Release, release-all and failed requests finish in S_EXEC; a granted allocate also passes S_FIN.
// A new word is taken only in S_IDLE, after the previous word has left S_EXEC (and S_FIN).
// The next word is taken once the result register is empty or being drained.
// Reset: asynchronous, active low; every class gets a full pool and head 0 valid.
// The link table is not cleared; it is seeded lazily as allocates advance.
module size_class_pool_allocator_top import scpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [31:0]       wanted_size,
	input  logic [CLS_W-1:0]  free_class,
	input  logic [OFF_W-1:0]  free_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [CLS_W-1:0]  got_class,
	output logic [OFF_W-1:0]  got_offset
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	cfg_t cfg;

	scpa_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	state_t           state_q;
	action_t          act_s1;
	logic [31:0]      want_s1;
	logic [CLS_W-1:0] fcls_s1;
	logic [OFF_W-1:0] foff_s1;

	logic [CNT_W-1:0] free_cnt_q [NUM_CLASSES];
	logic [CNT_W-1:0] init_cnt_q [NUM_CLASSES];
	logic [IDX_W-1:0] head_q     [NUM_CLASSES];
	logic             hvalid_q   [NUM_CLASSES];

	logic [CLS_W-1:0] c_s2;
	logic [IDX_W-1:0] h_s2;
	logic             empty_s2;
	logic             fwd_s2;
	logic [CNT_W-1:0] fwd_val_s2;

	logic             out_valid_q;
	status_t          status_q;
	logic [CLS_W-1:0] gcls_q;
	logic [OFF_W-1:0] goff_q;

	// Datapath decode of the held word
	logic [5:0]       cl;
	logic [5:0]       creq;
	logic [CLS_W-1:0] c;
	logic             too_large;
	logic             full;
	logic [4:0]       sh;
	logic [OFF_W-1:0] lim;
	logic             bad_addr;
	logic [IDX_W-1:0] fidx;
	logic             do_init;
	logic [CNT_W-1:0] nx;
	logic             grant;
	status_t          exec_st;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CNT_W-1:0]  mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CNT_W-1:0]  mem_rdata;

	assign in_ready   = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign got_class  = gcls_q;
	assign got_offset = goff_q;

	always_comb begin
		cl        = ceil_log2_32(want_s1);
		creq      = (cl > 6'(cfg.lg)) ? cl - 6'(cfg.lg) : 6'd0;
		c         = creq[CLS_W-1:0];
		too_large = (want_s1 > cfg.max_fast) || (creq >= 6'(cfg.ncls));
		full      = (free_cnt_q[c] == '0) || !hvalid_q[c] || (CNT_W'(head_q[c]) >= cfg.act);
		sh        = 5'(cfg.lg) + 5'(fcls_s1);
		lim       = OFF_W'(cfg.act) << sh;
		bad_addr  = ((CLS_W+1)'(fcls_s1) >= cfg.ncls) || (foff_s1 >= lim);
		fidx      = IDX_W'(foff_s1 >> sh);
		do_init   = init_cnt_q[c] < cfg.act;
		nx        = fwd_s2 ? fwd_val_s2 : mem_rdata;
		grant     = (act_s1 == ACT_ALLOC) && !too_large && !full;
		unique case (act_s1)
			ACT_ALLOC: exec_st = too_large ? ST_TOO_LARGE : (full ? ST_FULL : ST_DONE);
			ACT_FREE:  exec_st = bad_addr ? ST_BAD_ADDR : ST_DONE;
			default:   exec_st = ST_DONE;
		endcase
	end

	// Link table port usage: allocate seeds one entry while its class is not fully seeded and reads the head link,
	// release writes the old head (or the end marker when the list is empty) into the freed chunk.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = {c, head_q[c]};
		if (state_q == S_EXEC) begin
			if (act_s1 == ACT_ALLOC && !too_large && !full) begin
				mem_re    = 1'b1;
				mem_we    = do_init;
				mem_waddr = {c, init_cnt_q[c][IDX_W-1:0]};
				mem_wdata = init_cnt_q[c] + CNT_W'(1);
			end else if (act_s1 == ACT_FREE && !bad_addr) begin
				mem_we    = 1'b1;
				mem_waddr = {fcls_s1, fidx};
				mem_wdata = hvalid_q[fcls_s1] ? CNT_W'(head_q[fcls_s1]) : cfg.act;
			end
		end
	end

	scpa_link_ram u_link (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_s1  <= action_t'(action);
			want_s1 <= wanted_size;
			fcls_s1 <= free_class;
			foff_s1 <= free_offset;
		end
		if (state_q == S_EXEC) begin
			c_s2       <= c;
			h_s2       <= head_q[c];
			empty_s2   <= (free_cnt_q[c] == CNT_W'(1));
			fwd_s2     <= do_init && (init_cnt_q[c][IDX_W-1:0] == head_q[c]);
			fwd_val_s2 <= init_cnt_q[c] + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			gcls_q      <= '0;
			goff_q      <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				free_cnt_q[i] <= CNT_W'(CHUNKS);
				init_cnt_q[i] <= '0;
				head_q[i]     <= '0;
				hvalid_q[i]   <= 1'b1;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_valid_q && out_ready) out_valid_q <= 1'b0;
					if (in_valid && in_ready) state_q <= S_EXEC;
				end
				S_EXEC: begin
					// hold the result of a granted allocate until the head link returns
					state_q     <= grant ? S_FIN : S_IDLE;
					out_valid_q <= !grant;
					status_q    <= exec_st;
					gcls_q      <= '0;
					goff_q      <= '0;
					unique case (act_s1)
						ACT_ALLOC: begin
							if (grant) begin
								free_cnt_q[c] <= free_cnt_q[c] - CNT_W'(1);
								if (do_init) init_cnt_q[c] <= init_cnt_q[c] + CNT_W'(1);
							end
						end
						ACT_FREE: begin
							if (!bad_addr) begin
								head_q[fcls_s1]   <= fidx;
								hvalid_q[fcls_s1] <= 1'b1;
								if (free_cnt_q[fcls_s1] < cfg.act)
									free_cnt_q[fcls_s1] <= free_cnt_q[fcls_s1] + CNT_W'(1);
							end
						end
						ACT_FREE_ALL: begin
							for (int i = 0; i < NUM_CLASSES; i++) begin
								free_cnt_q[i] <= cfg.act;
								init_cnt_q[i] <= '0;
								head_q[i]     <= '0;
								hvalid_q[i]   <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				S_FIN: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					status_q    <= ST_DONE;
					gcls_q      <= c_s2;
					goff_q      <= OFF_W'(h_s2) << (5'(cfg.lg) + 5'(c_s2));
					if (empty_s2 || nx >= cfg.act) hvalid_q[c_s2] <= 1'b0;
					else                           head_q[c_s2]   <= nx[IDX_W-1:0];
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC) else $error("accept did not start work");
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> out_valid_q && status_q == ST_DONE)
		else $error("granted allocate gave no result");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> free_cnt_q[c_s2] < CNT_W'(CHUNKS))
		else $error("free count not decremented");
`endif

endmodule

>>> hdl/scpa_link_ram.sv
// Link table memory: one write port, one registered read port.
module scpa_link_ram import scpa_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CNT_W-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CNT_W-1:0]  rdata
);

	logic [CNT_W-1:0] mem [LINK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

>>> hdl/scpa_cfg_regs.sv
// APB configuration registers and the derived effective settings.
module scpa_cfg_regs import scpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [3:0]       min_log2_q;
	logic [31:0]      max_fast_q;
	logic [CNT_W-1:0] active_q;
	logic [CLS_W:0]   ncls_q;
	reg_idx_t         ridx;
	logic [3:0]       lg;
	logic [CNT_W-1:0] act;
	logic [5:0]       ncl;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_log2_q <= 4'(LG_MIN);
			max_fast_q <= 32'd4096;
			active_q   <= CNT_W'(CHUNKS);
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_MIN_LOG2: min_log2_q <= pwdata[3:0];
				REG_MAX_FAST: max_fast_q <= pwdata;
				REG_ACTIVE:   active_q   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_MIN_LOG2: prdata = {28'd0, min_log2_q};
			REG_MAX_FAST: prdata = max_fast_q;
			REG_ACTIVE:   prdata = {{(32-CNT_W){1'b0}}, active_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		if (min_log2_q < 4'(LG_MIN))      lg = 4'(LG_MIN);
		else if (min_log2_q > 4'(LG_MAX)) lg = 4'(LG_MAX);
		else                              lg = min_log2_q;
		if (active_q == '0)                   act = CNT_W'(1);
		else if (active_q > CNT_W'(CHUNKS))   act = CNT_W'(CHUNKS);
		else                                  act = active_q;
		ncl = ceil_log2_32(max_fast_q >> lg) + 6'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncls_q <= '0;
		end else if (ncl > 6'(NUM_CLASSES)) begin
			ncls_q <= (CLS_W+1)'(NUM_CLASSES);
		end else begin
			ncls_q <= ncl[CLS_W:0];
		end
	end

	assign cfg.lg       = lg;
	assign cfg.max_fast = max_fast_q;
	assign cfg.act      = act;
	assign cfg.ncls     = ncls_q;

endmodule

>>> tb/tb.sv
// Testbench for the size-class pool allocator: directed and random traffic against a predictor.
module tb;
	import scpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        action = ACT_NONE;
	logic [31:0]       wanted_size = '0;
	logic [CLS_W-1:0]  free_class = '0;
	logic [OFF_W-1:0]  free_offset = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        status;
	logic [CLS_W-1:0]  got_class;
	logic [OFF_W-1:0]  got_offset;

	size_class_pool_allocator_top i_dut (.*);

	always #10 clk = ~clk;

	typedef struct packed {
		logic [1:0]       st;
		logic [CLS_W-1:0] cls;
		logic [OFF_W-1:0] off;
	} grant_t;

	// Predicted allocator state
	logic [CNT_W-1:0] pm_link [LINK_DEPTH];
	logic [CNT_W-1:0] pm_free [NUM_CLASSES];
	logic [CNT_W-1:0] pm_init [NUM_CLASSES];
	logic [IDX_W-1:0] pm_head [NUM_CLASSES];
	logic             pm_hval [NUM_CLASSES];
	logic [3:0]       cfg_lg_raw = 4'd3;
	logic [31:0]      cfg_max_fast = 32'd4096;
	logic [10:0]      cfg_act_raw = 11'd1024;

	grant_t expected_q[$];
	int     mismatches = 0;
	longint cycles = 0;
	bit     stall_en = 1'b1;

	function automatic int clog2_64(longint unsigned n);
		longint unsigned t;
		int r;
		t = 1;
		r = 0;
		while (t < n) begin
			t <<= 1;
			r++;
		end
		return r;
	endfunction

	function automatic int eff_lg();
		if (cfg_lg_raw < 3) return 3;
		if (cfg_lg_raw > 12) return 12;
		return int'(cfg_lg_raw);
	endfunction

	function automatic int eff_act();
		if (cfg_act_raw < 1) return 1;
		if (cfg_act_raw > CHUNKS) return CHUNKS;
		return int'(cfg_act_raw);
	endfunction

	function automatic int live_classes();
		int n;
		n = 1 + clog2_64(longint'(cfg_max_fast >> eff_lg()));
		return n > NUM_CLASSES ? NUM_CLASSES : n;
	endfunction

	function automatic void refill_pools(int fc);
		for (int c = 0; c < NUM_CLASSES; c++) begin
			pm_free[c] = CNT_W'(fc);
			pm_init[c] = '0;
			pm_head[c] = '0;
			pm_hval[c] = 1'b1;
		end
	endfunction

	function automatic grant_t predict_grant(logic [1:0] act_in, logic [31:0] want,
			logic [3:0] fcls, logic [39:0] foff);
		grant_t g;
		int lg, act, ncls, c, h, base, nx, sh;
		lg = eff_lg();
		act = eff_act();
		ncls = live_classes();
		g = '0;
		if (act_in == ACT_ALLOC) begin
			c = clog2_64(longint'(want));
			c = c > lg ? c - lg : 0;
			if (want > cfg_max_fast || c >= ncls) g.st = ST_TOO_LARGE;
			else if (pm_free[c] == 0 || !pm_hval[c] || pm_head[c] >= act) g.st = ST_FULL;
			else begin
				base = c * CHUNKS;
				h = int'(pm_head[c]);
				if (pm_init[c] < act) begin
					pm_link[base + int'(pm_init[c])] = pm_init[c] + CNT_W'(1);
					pm_init[c]++;
				end
				pm_free[c]--;
				if (pm_free[c] != 0) begin
					nx = int'(pm_link[base + h]);
					if (nx < act) pm_head[c] = IDX_W'(nx);
					else pm_hval[c] = 1'b0;
				end else pm_hval[c] = 1'b0;
				g.st = ST_DONE;
				g.cls = CLS_W'(c);
				g.off = OFF_W'(longint'(h) << (lg + c));
			end
		end else if (act_in == ACT_FREE) begin
			sh = lg + int'(fcls);
			if (fcls >= ncls || longint'(foff) >= (longint'(act) << sh)) g.st = ST_BAD_ADDR;
			else begin
				base = int'(fcls) * CHUNKS;
				pm_link[base + int'(foff >> sh)] = pm_hval[fcls] ? CNT_W'(pm_head[fcls])
					: CNT_W'(act);
				pm_head[fcls] = IDX_W'(foff >> sh);
				pm_hval[fcls] = 1'b1;
				if (pm_free[fcls] < act) pm_free[fcls]++;
			end
		end else if (act_in == ACT_FREE_ALL) refill_pools(act);
		return g;
	endfunction

	// Track which chunks are currently handed out so releases stay legal
	longint unsigned held_q[$];

	// Valid stays up from one word to the next; it drops only for a gap or a drain
	task automatic send_word(logic [1:0] a, logic [31:0] w, logic [3:0] fc, logic [39:0] fo);
		grant_t g;
		if (stall_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		action <= a;
		wanted_size <= w;
		free_class <= fc;
		free_offset <= fo;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		g = predict_grant(a, w, fc, fo);
		expected_q = {expected_q, g};
		if (a == ACT_ALLOC && g.st == ST_DONE) held_q = {held_q, 64'({g.cls, g.off})};
		if (a == ACT_FREE_ALL) held_q.delete();
	endtask

	task automatic do_alloc(logic [31:0] w);
		send_word(ACT_ALLOC, w, 4'($urandom), {$urandom, $urandom});
	endtask

	task automatic do_free(logic [3:0] fc, logic [39:0] fo);
		send_word(ACT_FREE, $urandom, fc, fo);
	endtask

	// Release a chunk that is out, so no double free happens
	task automatic free_held();
		int k;
		longint unsigned e;
		k = $urandom_range(0, held_q.size() - 1);
		e = held_q[k];
		held_q.delete(k);
		do_free(e[43:40], e[39:0]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 4'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MIN_LOG2: cfg_lg_raw = val[3:0];
			REG_MAX_FAST: cfg_max_fast = val;
			REG_ACTIVE:   cfg_act_raw = val[10:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [3:0] lg, logic [31:0] mf, logic [10:0] act);
		drain();
		reg_write(REG_MIN_LOG2, lg);
		reg_write(REG_MAX_FAST, mf);
		reg_write(REG_ACTIVE, act);
		// stale list heads may point past a shrunk pool; start from clean pools
		send_word(ACT_FREE_ALL, '0, '0, '0);
	endtask

	task automatic test_directed();
		do_alloc(32'd0);
		do_alloc(32'd1);
		do_alloc(32'd8);
		do_alloc(32'd9);
		do_alloc(32'd4096);
		do_alloc(32'd4097);
		do_alloc(32'hFFFF_FFFF);
		free_held();
		free_held();
		do_free(4'd15, 40'd0);
		do_free(4'd0, 40'hFF_FFFF_FFFF);
		do_free(4'd0, 40'd8191);
		do_free(4'd0, 40'd8192);
		send_word(ACT_NONE, 32'hFFFF_FFFF, 4'hF, 40'hFF_FFFF_FFFF);
		send_word(ACT_FREE_ALL, '0, '0, '0);
		do_alloc(32'd16);
	endtask

	// Tiny pools: hit class full, end of list, and free-count saturation
	task automatic test_small_pool();
		set_config(4'd0, 32'd64, 11'd0);
		repeat (3) do_alloc(32'd8);
		free_held();
		do_free(4'd0, 40'd0);
		do_free(4'd0, 40'd7);
		do_alloc(32'd8);
		do_alloc(32'd8);
		set_config(4'd2, 32'd200, 11'd3);
		repeat (5) do_alloc(32'($urandom_range(1, 32)));
		while (held_q.size() != 0) free_held();
		repeat (4) do_alloc(32'($urandom_range(1, 16)));
	endtask

	task automatic random_phase(int n, int max_sz);
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 50) do_alloc($urandom_range(0, 5) == 0 ? $urandom : 32'($urandom_range(0, max_sz)));
			else if (r < 85 && held_q.size() != 0) free_held();
			else if (r < 93)
				do_free(4'($urandom), $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
					: 40'($urandom_range(0, 1 << 20)));
			else if (r < 96) send_word(ACT_FREE_ALL, $urandom, 4'($urandom), {$urandom, $urandom});
			else send_word(ACT_NONE, $urandom, 4'($urandom), {$urandom, $urandom});
		end
	endtask

	task automatic test_random();
		set_config(4'd3, 32'd4096, 11'd8);
		random_phase(400, 5000);
		set_config(4'd15, 32'hFFFF_FFFF, 11'd2047);
		random_phase(300, 32'h00FF_FFFF);
		stall_en = 1'b0;
		set_config(4'd12, 32'd8, 11'd1);
		random_phase(150, 9000);
		stall_en = 1'b1;
		set_config(4'($urandom_range(3, 6)), 32'($urandom_range(8, 70000)), 11'($urandom_range(2, 20)));
		random_phase(400, 70000);
		// hold off until every result is back, then continue
		drain();
		set_config(4'd5, 32'd1 << 20, 11'd1024);
		random_phase(400, 1 << 20);
	endtask

	// Receiver stall pattern
	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		grant_t e;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: st=%0d cls=%0d off=%0h",
					status, got_class, got_offset);
			end else begin
				e = expected_q.pop_front();
				if (status !== e.st || got_class !== e.cls || got_offset !== e.off) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d cls=%0d off=%0h got st=%0d cls=%0d off=%0h",
							e.st, e.cls, e.off, status, got_class, got_offset);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		refill_pools(CHUNKS);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_small_pool();
		test_random();
		drain();
		if (mismatches == 0 && expected_q.size() == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end
endmodule
